// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define EBD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define EBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// What must hold in the cycle after a reset edge.
`define EBD_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ebd_pkg.sv =====
// Shared types, codes and helpers of the edge blur diffusion block.
package ebd_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 10;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_COLOR_MODE   = 3'd2,
      CSR_EDGE_LEVEL   = 3'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      TINT_BLUE  = 2'd0,
      TINT_GREEN = 2'd1,
      TINT_RED   = 2'd2,
      TINT_WHITE = 2'd3
   } tint_type;

   localparam logic [9:0] FRAME_WIDTH_RESET  = 10'd640;
   localparam logic [8:0] FRAME_HEIGHT_RESET = 9'd480;
   localparam logic [7:0] EDGE_LEVEL_RESET   = 8'd64;
   localparam int unsigned MIN_DIM = 3;

   // Lines are interleaved over three RAMs so that three adjacent lines
   // can be read together.
   localparam int unsigned ROW_PHASES = 3;
   localparam logic [1:0]  PHASE_LAST = 2'd2;

   typedef struct packed {
      logic       interior;
      logic       last;
      logic       bank;      // bank holding the previous frame
      logic [1:0] row_mod;   // line number modulo three
   } scan_ctl_type;

   function automatic logic [1:0] mod3_next(input logic [1:0] m);
      return (m == PHASE_LAST) ? 2'd0 : m + 2'd1;
   endfunction

   function automatic logic [1:0] mod3_prev(input logic [1:0] m);
      return (m == 2'd0) ? PHASE_LAST : m - 2'd1;
   endfunction

endpackage

// ===== hw/rtl/ebd_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
module ebd_ram #(
   parameter int unsigned WIDTH = 5,
   parameter int unsigned DEPTH = 1024,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== hw/rtl/ebd_scan.sv =====
// Raster position counters, border decode and store address generation.
module ebd_scan import ebd_pkg::*; #(
   parameter int unsigned MAX_WIDTH  = 640,
   parameter int unsigned MAX_HEIGHT = 480,
   localparam int unsigned COL_W = $clog2(MAX_WIDTH),
   localparam int unsigned WD_W  = COL_W + 1,
   localparam int unsigned ROW_W = $clog2(MAX_HEIGHT),
   localparam int unsigned HD_W  = ROW_W + 1,
   localparam int unsigned BANK_DEPTH =
      ((MAX_HEIGHT + ROW_PHASES - 1) / ROW_PHASES) * MAX_WIDTH,
   localparam int unsigned ADDR_W = $clog2(BANK_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [WD_W-1:0]   width_eff,
   input  logic [HD_W-1:0]   height_eff,
   output scan_ctl_type      scan_ctl,
   output logic [ADDR_W-1:0] rd_addr_a [ROW_PHASES],
   output logic [ADDR_W-1:0] rd_addr_b [ROW_PHASES],
   output logic [ADDR_W-1:0] pix_addr
);

   localparam logic [ADDR_W-1:0] LINE_STEP = ADDR_W'(MAX_WIDTH);

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [1:0]        mod_ff, mod_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic              bank_ff, bank_in;

   // position of the current pixel after any restart for a size change
   logic [COL_W-1:0]  cur_col;
   logic [ROW_W-1:0]  cur_row;
   logic [1:0]        cur_mod;
   logic [ADDR_W-1:0] cur_base;
   logic [HD_W-1:0]   try_row;
   logic [1:0]        try_mod;
   logic [ADDR_W-1:0] try_base;
   logic [WD_W-1:0]   col_inc;
   logic [HD_W-1:0]   row_inc;
   logic [ADDR_W-1:0] col_addr;
   logic [ADDR_W-1:0] centre;
   logic [ADDR_W-1:0] base_up;
   logic [ADDR_W-1:0] base_dn;
   logic [1:0]        mod_up;
   logic [1:0]        mod_dn;

   always_comb begin
      if (WD_W'(col_ff) >= width_eff) begin
         cur_col  = '0;
         try_row  = HD_W'(row_ff) + HD_W'(1);
         try_mod  = mod3_next(mod_ff);
         try_base = (mod_ff == PHASE_LAST) ? base_ff + LINE_STEP : base_ff;
      end else begin
         cur_col  = col_ff;
         try_row  = HD_W'(row_ff);
         try_mod  = mod_ff;
         try_base = base_ff;
      end
      if (try_row >= height_eff) begin
         cur_row  = '0;
         cur_mod  = '0;
         cur_base = '0;
      end else begin
         cur_row  = try_row[ROW_W-1:0];
         cur_mod  = try_mod;
         cur_base = try_base;
      end
   end

   always_comb begin
      scan_ctl.interior = (cur_col != '0) && (WD_W'(cur_col) < width_eff - WD_W'(1)) &&
                          (cur_row != '0) && (HD_W'(cur_row) < height_eff - HD_W'(1));
      scan_ctl.last     = (WD_W'(cur_col) == width_eff - WD_W'(1)) &&
                          (HD_W'(cur_row) == height_eff - HD_W'(1));
      scan_ctl.bank     = bank_ff;
      scan_ctl.row_mod  = cur_mod;
   end

   // advance to the next pixel
   always_comb begin
      col_inc = WD_W'(cur_col) + WD_W'(1);
      row_inc = HD_W'(cur_row) + HD_W'(1);
      bank_in = bank_ff;
      if (col_inc >= width_eff) begin
         col_in = '0;
         if (row_inc >= height_eff) begin
            row_in  = '0;
            mod_in  = '0;
            base_in = '0;
            bank_in = ~bank_ff;
         end else begin
            row_in  = row_inc[ROW_W-1:0];
            mod_in  = mod3_next(cur_mod);
            base_in = (cur_mod == PHASE_LAST) ? cur_base + LINE_STEP : cur_base;
         end
      end else begin
         col_in  = col_inc[COL_W-1:0];
         row_in  = cur_row;
         mod_in  = cur_mod;
         base_in = cur_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         mod_ff  <= '0;
         base_ff <= '0;
         bank_ff <= 1'b0;
      end else if (step) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         mod_ff  <= mod_in;
         base_ff <= base_in;
         bank_ff <= bank_in;
      end
   end

   // neighbour addresses; each line RAM serves one of the three lines
   always_comb begin
      col_addr = ADDR_W'(cur_col);
      centre   = cur_base + col_addr;
      mod_up   = mod3_prev(cur_mod);
      mod_dn   = mod3_next(cur_mod);
      base_up  = (cur_mod == 2'd0) ? cur_base - LINE_STEP : cur_base;
      base_dn  = (cur_mod == PHASE_LAST) ? cur_base + LINE_STEP : cur_base;
      for (int k = 0; k < ROW_PHASES; k++) begin
         if (cur_mod == 2'(k)) begin
            rd_addr_a[k] = centre - ADDR_W'(1);
            rd_addr_b[k] = centre + ADDR_W'(1);
         end else if (mod_up == 2'(k)) begin
            rd_addr_a[k] = base_up + col_addr;
            rd_addr_b[k] = base_up + col_addr;
         end else begin
            rd_addr_a[k] = base_dn + col_addr;
            rd_addr_b[k] = base_dn + col_addr;
         end
      end
      pix_addr = centre;
   end

endmodule

// ===== hw/rtl/ebd_blur.sv =====
// Diffusion of the neighbour levels and mapping of the level to a tint.
module ebd_blur import ebd_pkg::*; #(
   parameter int unsigned FULL_BLUR = 31,
   localparam int unsigned LEVEL_W = $clog2(FULL_BLUR + 1)
) (
   input  logic [LEVEL_W-1:0] level_up,
   input  logic [LEVEL_W-1:0] level_left,
   input  logic [LEVEL_W-1:0] level_right,
   input  logic [LEVEL_W-1:0] level_down,
   input  logic               edge_hit,
   input  logic               interior,
   input  tint_type           color_mode,
   output logic [LEVEL_W-1:0] level,
   output logic [23:0]        pixel_color
);

   localparam logic [LEVEL_W+1:0] DECAY = (LEVEL_W + 2)'(3);

   logic [LEVEL_W+1:0] sum;
   logic [LEVEL_W+1:0] sum_adj;
   logic [7:0]         ramp [2**LEVEL_W];
   logic [7:0]         shade;

   // ramp 255*i/FULL_BLUR, fixed at elaboration
   for (genvar i = 0; i < 2**LEVEL_W; i++) begin : g_ramp
      localparam int unsigned RampRaw = (i * 255) / FULL_BLUR;
      assign ramp[i] = 8'((RampRaw > 255) ? 255 : RampRaw);
   end

   always_comb begin
      sum = (LEVEL_W + 2)'(level_up) + (LEVEL_W + 2)'(level_left) +
            (LEVEL_W + 2)'(level_right) + (LEVEL_W + 2)'(level_down);
      sum_adj = (sum > DECAY) ? sum - DECAY : sum;
      level   = edge_hit ? LEVEL_W'(FULL_BLUR) : sum_adj[LEVEL_W+1:2];
      shade   = ramp[level];
   end

   always_comb begin
      if (!interior) begin
         pixel_color = '0;
      end else begin
         case (color_mode)
            TINT_BLUE:  pixel_color = {16'h0, shade};
            TINT_GREEN: pixel_color = {8'h0, shade, 8'h0};
            TINT_RED:   pixel_color = {shade, 16'h0};
            TINT_WHITE: pixel_color = {shade, shade, shade};
         endcase
      end
   end

endmodule

// ===== hw/rtl/edge_blur_diffusion_top.sv =====
// Top level of the edge blur diffusion pixel stream processor.

// Takes one edge-strength byte per pixel in raster order and returns one
// RGB colour per pixel, one transaction in and one out per clock when the
// result side keeps rsp_ready high. A pixel passes two registers: the
// accepted transaction issues the neighbour reads of the previous frame's
// blur store, and the registered read data is then diffused, tinted and
// written into the result register when it is free; the result waits
// on the rsp_ ports until taken at an edge with rsp_ready high. The rate
// is set by the store: each of its two frame banks is split into three
// line-interleaved RAMs, each with one write port and two read ports, so
// the three lines around a pixel are read together while the level of the
// previous pixel is written to the other bank. After reset a clearing
// pass zeroes the store, one entry of every RAM per cycle, over all
// ceil(MAX_HEIGHT/3)*MAX_WIDTH entries (102400 at the default size);
// req_ready stays low during it while configuration writes are still
// taken. Registers: frame_width and frame_height (clamped to 3..MAX_WIDTH and
// 3..MAX_HEIGHT), color_mode and edge_level; write them only while no pixel
// is in flight. Border pixels give black and are not stored; rsp_frame_end
// marks the last pixel of each frame, after which the banks swap.
module edge_blur_diffusion_top import ebd_pkg::*; #(
   parameter int unsigned MAX_WIDTH  = 640,
   parameter int unsigned MAX_HEIGHT = 480,
   parameter int unsigned FULL_BLUR  = 31
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_edge_strength,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [23:0]            rsp_pixel_color,
   output logic                   rsp_frame_end,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
   localparam int unsigned WD_W    = COL_W + 1;
   localparam int unsigned ROW_W   = $clog2(MAX_HEIGHT);
   localparam int unsigned HD_W    = ROW_W + 1;
   localparam int unsigned LEVEL_W = $clog2(FULL_BLUR + 1);
   localparam int unsigned BANK_DEPTH =
      ((MAX_HEIGHT + ROW_PHASES - 1) / ROW_PHASES) * MAX_WIDTH;
   localparam int unsigned ADDR_W  = $clog2(BANK_DEPTH);
   localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(BANK_DEPTH - 1);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [9:0] frame_width_ff,  frame_width_in;
   logic [8:0] frame_height_ff, frame_height_in;
   tint_type   color_mode_ff,   color_mode_in;
   logic [7:0] edge_level_ff,   edge_level_in;

   assign csr_ready = 1'b1;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      color_mode_in   = color_mode_ff;
      edge_level_in   = edge_level_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata[8:0];
            CSR_COLOR_MODE:   color_mode_in   = tint_type'(csr_wdata[1:0]);
            CSR_EDGE_LEVEL:   edge_level_in   = csr_wdata[7:0];
            default: ;        // unused index: write is dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         color_mode_ff   <= TINT_BLUE;
         edge_level_ff   <= EDGE_LEVEL_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         color_mode_ff   <= color_mode_in;
         edge_level_ff   <= edge_level_in;
      end
   end

   // clamp the frame size to the supported range
   logic [31:0]     width_raw;
   logic [31:0]     height_raw;
   logic [WD_W-1:0] width_eff;
   logic [HD_W-1:0] height_eff;

   assign width_raw  = 32'(frame_width_ff);
   assign height_raw = 32'(frame_height_ff);

   always_comb begin
      if (width_raw < MIN_DIM) begin
         width_eff = WD_W'(MIN_DIM);
      end else if (width_raw > MAX_WIDTH) begin
         width_eff = WD_W'(MAX_WIDTH);
      end else begin
         width_eff = width_raw[WD_W-1:0];
      end
      if (height_raw < MIN_DIM) begin
         height_eff = HD_W'(MIN_DIM);
      end else if (height_raw > MAX_HEIGHT) begin
         height_eff = HD_W'(MAX_HEIGHT);
      end else begin
         height_eff = height_raw[HD_W-1:0];
      end
   end

   // ---------------------------------------------------------------
   // Clearing pass after reset
   // ---------------------------------------------------------------
   logic              clear_ff,      clear_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;

   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + ADDR_W'(1);
         if (clear_addr_ff == CLEAR_LAST) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   // ---------------------------------------------------------------
   // Handshake: read stage and result register can both hold a pixel
   // ---------------------------------------------------------------
   logic out_free;
   logic s1_advance;
   logic accept;
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_ready  = !clear_ff && (!s1_valid_ff || out_free);
   assign accept     = req_valid && req_ready;

   // ---------------------------------------------------------------
   // Position tracking and neighbour addresses
   // ---------------------------------------------------------------
   scan_ctl_type      scan_ctl;
   logic [ADDR_W-1:0] scan_rd_addr_a [ROW_PHASES];
   logic [ADDR_W-1:0] scan_rd_addr_b [ROW_PHASES];
   logic [ADDR_W-1:0] scan_pix_addr;

   ebd_scan #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .scan_ctl   (scan_ctl),
      .rd_addr_a  (scan_rd_addr_a),
      .rd_addr_b  (scan_rd_addr_b),
      .pix_addr   (scan_pix_addr)
   );

   // ---------------------------------------------------------------
   // Read stage registers
   // ---------------------------------------------------------------
   scan_ctl_type      s1_ctl_ff,  s1_ctl_in;
   logic [ADDR_W-1:0] s1_addr_ff, s1_addr_in;
   logic              s1_edge_ff, s1_edge_in;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_ctl_in   = s1_ctl_ff;
      s1_addr_in  = s1_addr_ff;
      s1_edge_in  = s1_edge_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_ctl_in   = scan_ctl;
         s1_addr_in  = scan_pix_addr;
         s1_edge_in  = req_edge_strength > edge_level_ff;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_ctl_ff  <= s1_ctl_in;
      s1_addr_ff <= s1_addr_in;
      s1_edge_ff <= s1_edge_in;
   end

   // ---------------------------------------------------------------
   // Blur store: two frame banks, three line RAMs each
   // ---------------------------------------------------------------
   logic [LEVEL_W-1:0] rd_a [2][ROW_PHASES];
   logic [LEVEL_W-1:0] rd_b [2][ROW_PHASES];
   logic [LEVEL_W-1:0] blur_level;
   logic [23:0]        blur_color;

   for (genvar fb = 0; fb < 2; fb++) begin : g_bank
      for (genvar rb = 0; rb < ROW_PHASES; rb++) begin : g_line
         logic               wr_en;
         logic [ADDR_W-1:0]  wr_addr;
         logic [LEVEL_W-1:0] wr_data;
         logic               rd_en;

         // the bank that is not being read takes the new levels
         assign wr_en   = clear_ff ||
                          (s1_advance && s1_ctl_ff.interior &&
                           (s1_ctl_ff.bank != 1'(fb)) && (s1_ctl_ff.row_mod == 2'(rb)));
         assign wr_addr = clear_ff ? clear_addr_ff : s1_addr_ff;
         assign wr_data = clear_ff ? '0 : blur_level;
         assign rd_en   = accept && scan_ctl.interior && (scan_ctl.bank == 1'(fb));

         ebd_ram #(
            .WIDTH (LEVEL_W),
            .DEPTH (BANK_DEPTH)
         ) u_ram (
            .clock     (clock),
            .wr_en     (wr_en),
            .wr_addr   (wr_addr),
            .wr_data   (wr_data),
            .rd_en     (rd_en),
            .rd_addr_a (scan_rd_addr_a[rb]),
            .rd_addr_b (scan_rd_addr_b[rb]),
            .rd_data_a (rd_a[fb][rb]),
            .rd_data_b (rd_b[fb][rb])
         );
      end
   end

   // pick the four neighbours by the line phase of the pixel
   logic [LEVEL_W-1:0] nb_up, nb_left, nb_right, nb_down;

   always_comb begin
      nb_left  = rd_a[s1_ctl_ff.bank][s1_ctl_ff.row_mod];
      nb_right = rd_b[s1_ctl_ff.bank][s1_ctl_ff.row_mod];
      nb_up    = rd_a[s1_ctl_ff.bank][mod3_prev(s1_ctl_ff.row_mod)];
      nb_down  = rd_a[s1_ctl_ff.bank][mod3_next(s1_ctl_ff.row_mod)];
   end

   ebd_blur #(
      .FULL_BLUR (FULL_BLUR)
   ) u_blur (
      .level_up    (nb_up),
      .level_left  (nb_left),
      .level_right (nb_right),
      .level_down  (nb_down),
      .edge_hit    (s1_edge_ff),
      .interior    (s1_ctl_ff.interior),
      .color_mode  (color_mode_ff),
      .level       (blur_level),
      .pixel_color (blur_color)
   );

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   logic [23:0] rsp_color_ff, rsp_color_in;
   logic        rsp_end_ff,   rsp_end_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_color_in = rsp_color_ff;
      rsp_end_in   = rsp_end_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
         rsp_color_in = blur_color;
         rsp_end_in   = s1_ctl_ff.last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_color_ff <= rsp_color_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_frame_end   = rsp_end_ff;

endmodule

// ===== hw/rtl/ebd_checker.sv =====
// Port-level assertion checker for the edge blur diffusion top, with its bind.
`include "assert_macros.svh"

module ebd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] rsp_pixel_color,
   input logic        rsp_frame_end
);

   // a stalled result keeps its payload
   `EBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pixel_color) && $stable(rsp_frame_end), "stalled result changed")

   // clearing pass blocks input right after reset
   `EBD_ASSERT_AFTER_RESET(a_clear_blocks, clock, reset, !req_ready, "input taken during clearing pass")

   `EBD_ASSERT_AFTER_RESET(a_reset_empty, clock, reset, !rsp_valid, "result pending after reset")

   // a tint has one channel lit, or all three equal
   `EBD_ASSERT_IMPL(a_tint_form, clock, reset, rsp_valid, ((rsp_pixel_color[23:16] == 8'h0) && (rsp_pixel_color[15:8] == 8'h0)) || ((rsp_pixel_color[15:8] == 8'h0) && (rsp_pixel_color[7:0] == 8'h0)) || ((rsp_pixel_color[23:16] == 8'h0) && (rsp_pixel_color[7:0] == 8'h0)) || ((rsp_pixel_color[23:16] == rsp_pixel_color[15:8]) && (rsp_pixel_color[15:8] == rsp_pixel_color[7:0])), "colour is not a tint")

   // the last pixel of a frame is a border pixel
   `EBD_ASSERT_IMPL(a_end_black, clock, reset, rsp_valid && rsp_frame_end, rsp_pixel_color == 24'h0, "frame end pixel not black")

endmodule

bind edge_blur_diffusion_top ebd_checker u_ebd_checker (.*);
